### design/rrts_pkg.sv
// Shared types, codes and sizes for the round-robin time-slice scheduler.
package rrts_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int SLICE_W = 6;

    // request codes
    localparam logic [2:0] REQ_CREATE  = 3'd0;
    localparam logic [2:0] REQ_TICK    = 3'd1;
    localparam logic [2:0] REQ_BLOCK   = 3'd2;
    localparam logic [2:0] REQ_UNBLOCK = 3'd3;
    localparam logic [2:0] REQ_ENTER   = 3'd4;
    localparam logic [2:0] REQ_EXIT    = 3'd5;

    // result codes
    localparam logic [2:0] RC_OK      = 3'd0;
    localparam logic [2:0] RC_FULL    = 3'd1;
    localparam logic [2:0] RC_NOPID   = 3'd2;
    localparam logic [2:0] RC_NOREADY = 3'd3;
    localparam logic [2:0] RC_NOTASK  = 3'd4;

    localparam logic [7:0]         PRIV_USER      = 8'd3;
    localparam logic [SLICE_W-1:0] PRIV_SLICE_RST = 6'd50;
    localparam logic [SLICE_W-1:0] USER_SLICE_RST = 6'd10;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_PENDING = 2'd2
    } slot_st_t;

    // saved status uses the same encoding; free means nothing saved
    localparam slot_st_t SV_NONE = ST_FREE;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] target_pid;
        logic [7:0] privilege;
    } cmd_t;

    typedef struct packed {
        logic [2:0] result_code;
        logic [3:0] new_pid;
        logic [3:0] running_pid;
        logic       running_valid;
        logic       switched;
    } rsp_t;

    typedef struct packed {
        logic               status_we;
        slot_st_t           status;
        logic               saved_we;
        slot_st_t           saved;
        logic               left_we;
        logic [SLICE_W-1:0] left;
        logic               dflt_we;
        logic [SLICE_W-1:0] dflt;
    } tbl_wr_t;

    typedef struct packed {
        slot_st_t           status;
        slot_st_t           saved;
        logic [SLICE_W-1:0] left;
        logic [SLICE_W-1:0] dflt;
    } tbl_rd_t;

endpackage

### design/rrts_slot_table.sv
// Per-slot task table with a single read/write port.
module rrts_slot_table
(
    input  logic             clk,
    input  logic             rst_n,
    input  rrts_pkg::idx_t   addr,
    input  rrts_pkg::tbl_wr_t wr,
    output rrts_pkg::tbl_rd_t rd
);

    rrts_pkg::slot_st_t             status_reg [rrts_pkg::SLOTS];
    rrts_pkg::slot_st_t             saved_reg  [rrts_pkg::SLOTS];
    logic [rrts_pkg::SLICE_W-1:0]   left_reg   [rrts_pkg::SLOTS];
    logic [rrts_pkg::SLICE_W-1:0]   dflt_reg   [rrts_pkg::SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrts_pkg::SLOTS; i++)
            begin
                status_reg[i] <= rrts_pkg::ST_FREE;
                saved_reg[i]  <= rrts_pkg::SV_NONE;
            end
        end
        else
        begin
            if (wr.status_we)
                status_reg[addr] <= wr.status;
            if (wr.saved_we)
                saved_reg[addr] <= wr.saved;
        end
    end

    // slice fields are only read for slots that create has filled
    always_ff @(posedge clk)
    begin
        if (wr.left_we)
            left_reg[addr] <= wr.left;
        if (wr.dflt_we)
            dflt_reg[addr] <= wr.dflt;
    end

    assign rd.status = status_reg[addr];
    assign rd.saved  = saved_reg[addr];
    assign rd.left   = left_reg[addr];
    assign rd.dflt   = dflt_reg[addr];

endmodule

### design/rrts_seq.sv
// Request sequencer: walks the slot table one entry per cycle.
module rrts_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  rrts_pkg::cmd_t                cmd,
    output logic                          busy,
    input  logic [rrts_pkg::SLICE_W-1:0]  priv_slice,
    input  logic [rrts_pkg::SLICE_W-1:0]  user_slice,
    output rrts_pkg::idx_t                tbl_addr,
    output rrts_pkg::tbl_wr_t             tbl_wr,
    input  rrts_pkg::tbl_rd_t             tbl_rd,
    output logic                          done,
    output rrts_pkg::rsp_t                result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP,
        S_SCAN
    } state_t;

    localparam rrts_pkg::idx_t LAST_IDX = rrts_pkg::idx_t'(rrts_pkg::SLOTS - 1);

    function automatic rrts_pkg::idx_t idx_inc(rrts_pkg::idx_t i);
        return (i == LAST_IDX) ? '0 : i + rrts_pkg::idx_t'(1);
    endfunction

    state_t          state_reg, state_next;
    rrts_pkg::idx_t  idx_reg, idx_next;
    rrts_pkg::idx_t  org_reg, org_next;
    rrts_pkg::cmd_t  op_reg, op_next;
    rrts_pkg::idx_t  cur_reg, cur_next;
    logic            cv_reg, cv_next;
    logic            done_reg, done_next;
    rrts_pkg::rsp_t  result_reg, result_next;

    logic                          fin;
    logic [2:0]                    rc;
    rrts_pkg::idx_t                newp;
    logic                          tgt_ok;
    logic                          is_cur;
    logic [rrts_pkg::SLICE_W-1:0]  new_slice;

    assign tgt_ok    = int'(op_reg.target_pid) < rrts_pkg::SLOTS;
    assign is_cur    = cv_reg && (idx_reg == cur_reg);
    assign new_slice = (op_reg.privilege < rrts_pkg::PRIV_USER) ? priv_slice : user_slice;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        org_next   = org_reg;
        op_next    = op_reg;
        cur_next   = cur_reg;
        cv_next    = cv_reg;
        tbl_addr   = idx_reg;
        tbl_wr     = '0;
        fin        = 1'b0;
        rc         = rrts_pkg::RC_OK;
        newp       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd;
                    state_next = S_OP;
                    case (cmd.req_type)
                        rrts_pkg::REQ_TICK:    idx_next = cur_reg;
                        rrts_pkg::REQ_BLOCK,
                        rrts_pkg::REQ_UNBLOCK: idx_next = rrts_pkg::idx_t'(cmd.target_pid);
                        default:               idx_next = '0;
                    endcase
                end
            end

            S_OP:
            begin
                case (op_reg.req_type)
                    rrts_pkg::REQ_CREATE:
                    begin
                        if (tbl_rd.status == rrts_pkg::ST_FREE)
                        begin
                            tbl_wr.status_we = 1'b1;
                            tbl_wr.status    = rrts_pkg::ST_READY;
                            tbl_wr.saved_we  = 1'b1;
                            tbl_wr.saved     = rrts_pkg::SV_NONE;
                            tbl_wr.left_we   = 1'b1;
                            tbl_wr.left      = new_slice;
                            tbl_wr.dflt_we   = 1'b1;
                            tbl_wr.dflt      = new_slice;
                            newp             = idx_reg;
                            fin              = 1'b1;
                            if (!cv_reg)
                            begin
                                cur_next = idx_reg;
                                cv_next  = 1'b1;
                            end
                        end
                        else if (idx_reg == LAST_IDX)
                        begin
                            fin = 1'b1;
                            rc  = rrts_pkg::RC_FULL;
                        end
                        else
                            idx_next = idx_inc(idx_reg);
                    end

                    rrts_pkg::REQ_TICK:
                    begin
                        if (!cv_reg)
                        begin
                            fin = 1'b1;
                            rc  = rrts_pkg::RC_NOTASK;
                        end
                        else if (tbl_rd.left != '0)
                        begin
                            tbl_wr.left_we = 1'b1;
                            tbl_wr.left    = tbl_rd.left - rrts_pkg::SLICE_W'(1);
                            fin            = 1'b1;
                        end
                        else
                        begin
                            // expired: reload, then scan the slots after it
                            tbl_wr.left_we = 1'b1;
                            tbl_wr.left    = tbl_rd.dflt;
                            org_next       = idx_reg;
                            idx_next       = idx_inc(idx_reg);
                            state_next     = S_SCAN;
                        end
                    end

                    rrts_pkg::REQ_BLOCK:
                    begin
                        if (!tgt_ok || tbl_rd.status == rrts_pkg::ST_FREE)
                        begin
                            fin = 1'b1;
                            rc  = rrts_pkg::RC_NOPID;
                        end
                        else
                        begin
                            tbl_wr.status_we = 1'b1;
                            tbl_wr.status    = rrts_pkg::ST_PENDING;
                            org_next         = idx_reg;
                            idx_next         = idx_inc(idx_reg);
                            state_next       = S_SCAN;
                        end
                    end

                    rrts_pkg::REQ_UNBLOCK:
                    begin
                        fin = 1'b1;
                        if (!tgt_ok || tbl_rd.status == rrts_pkg::ST_FREE)
                            rc = rrts_pkg::RC_NOPID;
                        else
                        begin
                            tbl_wr.status_we = 1'b1;
                            tbl_wr.status    = rrts_pkg::ST_READY;
                        end
                    end

                    rrts_pkg::REQ_ENTER:
                    begin
                        if (tbl_rd.status != rrts_pkg::ST_FREE && !is_cur)
                        begin
                            tbl_wr.saved_we  = 1'b1;
                            tbl_wr.saved     = tbl_rd.status;
                            tbl_wr.status_we = 1'b1;
                            tbl_wr.status    = rrts_pkg::ST_PENDING;
                        end
                        if (idx_reg == LAST_IDX)
                            fin = 1'b1;
                        else
                            idx_next = idx_inc(idx_reg);
                    end

                    rrts_pkg::REQ_EXIT:
                    begin
                        if (tbl_rd.status != rrts_pkg::ST_FREE &&
                            tbl_rd.saved != rrts_pkg::SV_NONE && !is_cur)
                        begin
                            tbl_wr.status_we = 1'b1;
                            tbl_wr.status    = tbl_rd.saved;
                            tbl_wr.saved_we  = 1'b1;
                            tbl_wr.saved     = rrts_pkg::SV_NONE;
                        end
                        if (idx_reg == LAST_IDX)
                            fin = 1'b1;
                        else
                            idx_next = idx_inc(idx_reg);
                    end

                    default:
                        fin = 1'b1;
                endcase
            end

            S_SCAN:
            begin
                if (tbl_rd.status == rrts_pkg::ST_READY)
                begin
                    cur_next = idx_reg;
                    cv_next  = 1'b1;
                    fin      = 1'b1;
                    if (op_reg.req_type == rrts_pkg::REQ_BLOCK)
                    begin
                        tbl_wr.left_we = 1'b1;
                        tbl_wr.left    = tbl_rd.dflt;
                    end
                end
                else if (idx_reg == org_reg)
                begin
                    fin = 1'b1;
                    rc  = rrts_pkg::RC_NOREADY;
                end
                else
                    idx_next = idx_inc(idx_reg);
            end

            default:
                state_next = S_IDLE;
        endcase

        if (fin)
            state_next = S_IDLE;

        done_next                 = fin;
        result_next.result_code   = rc;
        result_next.new_pid       = 4'(newp);
        result_next.running_pid   = cv_next ? 4'(cur_next) : 4'd0;
        result_next.running_valid = cv_next;
        result_next.switched      = (cv_next != cv_reg) || (cv_next && cur_next != cur_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            org_reg    <= '0;
            op_reg     <= '0;
            cur_reg    <= '0;
            cv_reg     <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            org_reg   <= org_next;
            op_reg    <= op_next;
            cur_reg   <= cur_next;
            cv_reg    <= cv_next;
            done_reg  <= done_next;
            if (fin)
                result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/round_robin_time_slice_scheduler_top.sv
// Top level of the round-robin time-slice scheduler with its APB register port.
//
// A request transfer is taken when start is high and busy is low; busy then
// stays high until the request is finished. Each request answers with exactly
// one result, shown on result for a single cycle with done high, in the cycle
// in which busy drops; the receiver cannot stall it, so sample it when done is
// seen. A request walks the slot table through its one read/write port, one
// slot per cycle: unblock, a tick that only counts down, a tick with no task,
// a bad target and unknown requests visit a single slot; create walks up from
// slot 0 to the lowest free slot, or to the last when the table is full;
// enter and exit critical visit every slot; an expiring tick or a block
// visits its own slot, then scans the slots after it round to itself. A new
// request may be started in the cycle its result is shown. Slice lengths are
// written over APB: privileged_slice at byte 0, user_slice at byte 4; write
// them only while the scheduler is idle.
module round_robin_time_slice_scheduler_top
(
    input  logic           clk,
    input  logic           rst_n,
    // request / result
    input  logic           start,
    output logic           busy,
    input  rrts_pkg::cmd_t cmd,
    output logic           done,
    output rrts_pkg::rsp_t result,
    // APB register port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam logic REG_PRIV_SLICE = 1'b0;
    localparam logic REG_USER_SLICE = 1'b1;

    logic [rrts_pkg::SLICE_W-1:0] priv_slice_reg;
    logic [rrts_pkg::SLICE_W-1:0] user_slice_reg;
    logic                         cfg_wr;

    rrts_pkg::idx_t    tbl_addr;
    rrts_pkg::tbl_wr_t tbl_wr;
    rrts_pkg::tbl_rd_t tbl_rd;

    // no wait states on the register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register index comes from the word address bit; low bits are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priv_slice_reg <= rrts_pkg::PRIV_SLICE_RST;
            user_slice_reg <= rrts_pkg::USER_SLICE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_PRIV_SLICE: priv_slice_reg <= pwdata[rrts_pkg::SLICE_W-1:0];
                REG_USER_SLICE: user_slice_reg <= pwdata[rrts_pkg::SLICE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PRIV_SLICE: prdata = 32'(priv_slice_reg);
            REG_USER_SLICE: prdata = 32'(user_slice_reg);
            default:        prdata = '0;
        endcase
    end

    // sequencer: decodes a request and steps through the slot table
    rrts_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .priv_slice (priv_slice_reg),
        .user_slice (user_slice_reg),
        .tbl_addr   (tbl_addr),
        .tbl_wr     (tbl_wr),
        .tbl_rd     (tbl_rd),
        .done       (done),
        .result     (result)
    );

    // status, saved status and slice counters of every slot
    rrts_slot_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (tbl_addr),
        .wr    (tbl_wr),
        .rd    (tbl_rd)
    );

endmodule

### design/rrts_checker.sv
// Port-level checks for the scheduler top, attached by bind.
module rrts_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input rrts_pkg::rsp_t result
);

    // an accepted request always raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // the result follows the end of busy and nothing else
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a finished request");

    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("request finished without a result");

    // no running task reads as slot zero, and a switch needs a running task
    a_idle_pid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.running_valid) |-> (result.running_pid == 4'd0 && !result.switched))
        else $error("running slot reported without a running task");

endmodule

bind round_robin_time_slice_scheduler_top rrts_checker u_rrts_checker (.*);

### tb/sv/tb_round_robin_time_slice_scheduler_top.sv
// Self-checking testbench for the round-robin time-slice scheduler top level.
`timescale 1ns / 100ps

module tb_round_robin_time_slice_scheduler_top;

    import rrts_pkg::*;

    // Request codes the block must ignore
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    // Register indexes; byte address is 4 * index
    localparam int REG_PRIV_SLICE = 0;
    localparam int REG_USER_SLICE = 1;

    localparam int RANDOM_ITEMS = 900;
    // Worst case per transfer is the longest busy run, one done cycle and the
    // longest sender gap; this is several times the slowest legal run.
    localparam int CYCLE_LIMIT  = 500000;

    // ------------------------------------------------------------------
    // Clock, reset and block pins
    // ------------------------------------------------------------------
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    cmd_t        cmd     = '0;
    logic        done;
    rsp_t        rsp;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    round_robin_time_slice_scheduler_top DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: slot table, running task and slice registers
    // ------------------------------------------------------------------
    slot_st_t     status_tbl [SLOTS];
    slot_st_t     saved_tbl  [SLOTS];
    logic [6:0]   left_tbl   [SLOTS];
    logic [5:0]   dflt_tbl   [SLOTS];
    idx_t         cur_slot   = '0;
    bit           cur_valid  = 1'b0;
    logic [5:0]   priv_len   = PRIV_SLICE_RST;
    logic [5:0]   user_len   = USER_SLICE_RST;

    cmd_t sched_cmds_q [$];     // requests waiting for the driver
    rsp_t rsp_expected_q [$];   // predicted results, oldest first

    int err_cnt    = 0;
    int stim_cnt   = 0;
    int switch_cnt = 0;
    int req_cnt [8];
    int rc_cnt  [8];
    int cycle_cnt  = 0;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            status_tbl[i] = ST_FREE;
            saved_tbl[i]  = SV_NONE;
            left_tbl[i]   = '0;
            dflt_tbl[i]   = '0;
        end
        for (int i = 0; i < 8; i++)
        begin
            req_cnt[i] = 0;
            rc_cnt[i]  = 0;
        end
    end

    // Circular search for a ready slot, starting after 'from' and ending on
    // 'from' itself. SLOTS means nothing is ready.
    function automatic int next_ready(int from);
        int s;
        for (int k = 1; k <= SLOTS; k++)
        begin
            s = (from + k) % SLOTS;
            if (status_tbl[s] == ST_READY)
                return s;
        end
        return SLOTS;
    endfunction

    // Apply one request to the shadow state and return the result it owes.
    function automatic rsp_t scheduler_step(cmd_t c);
        rsp_t r;
        int   s;
        int   tgt;
        idx_t prev_slot;
        bit   prev_valid;
        r          = '0;
        r.result_code = RC_OK;
        tgt        = int'(c.target_pid);
        prev_slot  = cur_slot;
        prev_valid = cur_valid;
        case (c.req_type)
            REQ_CREATE:
            begin
                s = SLOTS;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (status_tbl[i] == ST_FREE)
                        s = i;
                if (s >= SLOTS)
                    r.result_code = RC_FULL;
                else
                begin
                    // anything above user privilege counts as user
                    dflt_tbl[s]   = (c.privilege < PRIV_USER) ? priv_len : user_len;
                    left_tbl[s]   = {1'b0, dflt_tbl[s]};
                    status_tbl[s] = ST_READY;
                    saved_tbl[s]  = SV_NONE;
                    if (!cur_valid)
                    begin
                        cur_slot  = idx_t'(s);
                        cur_valid = 1'b1;
                    end
                    r.new_pid = 4'(s);
                end
            end
            REQ_TICK:
            begin
                if (!cur_valid)
                    r.result_code = RC_NOTASK;
                else if (left_tbl[cur_slot] != 0)
                    left_tbl[cur_slot] = left_tbl[cur_slot] - 7'd1;
                else
                begin
                    // slice expired: reload, then round-robin to the next ready task
                    left_tbl[cur_slot] = {1'b0, dflt_tbl[cur_slot]};
                    s = next_ready(int'(cur_slot));
                    if (s >= SLOTS)
                        r.result_code = RC_NOREADY;
                    else
                        cur_slot = idx_t'(s);
                end
            end
            REQ_BLOCK:
            begin
                if (tgt >= SLOTS || status_tbl[tgt] == ST_FREE)
                    r.result_code = RC_NOPID;
                else
                begin
                    status_tbl[tgt] = ST_PENDING;
                    s = next_ready(tgt);
                    if (s >= SLOTS)
                        r.result_code = RC_NOREADY;
                    else
                    begin
                        cur_slot    = idx_t'(s);
                        cur_valid   = 1'b1;
                        left_tbl[s] = {1'b0, dflt_tbl[s]};
                    end
                end
            end
            REQ_UNBLOCK:
            begin
                if (tgt >= SLOTS || status_tbl[tgt] == ST_FREE)
                    r.result_code = RC_NOPID;
                else
                    status_tbl[tgt] = ST_READY;
            end
            REQ_ENTER:
            begin
                // park everyone but the running task; nesting overwrites saves
                for (int i = 0; i < SLOTS; i++)
                    if (status_tbl[i] != ST_FREE && !(cur_valid && idx_t'(i) == cur_slot))
                    begin
                        saved_tbl[i]  = status_tbl[i];
                        status_tbl[i] = ST_PENDING;
                    end
            end
            REQ_EXIT:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (status_tbl[i] != ST_FREE && saved_tbl[i] != SV_NONE &&
                        !(cur_valid && idx_t'(i) == cur_slot))
                    begin
                        status_tbl[i] = saved_tbl[i];
                        saved_tbl[i]  = SV_NONE;
                    end
            end
            default: ;  // spare codes: no effect
        endcase
        r.running_pid   = cur_valid ? 4'(cur_slot) : 4'd0;
        r.running_valid = cur_valid;
        r.switched      = (cur_valid != prev_valid) || (cur_valid && cur_slot != prev_slot);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of back-to-back transfers with random gaps,
    // now and then holding off until every result is back.
    // ------------------------------------------------------------------
    int   burst_left  = 4;
    int   gap_left    = 0;
    bit   drain_wait  = 1'b0;
    bit   present_nxt;
    rsp_t predicted;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            // a presented request is held until busy is low at an edge
            present_nxt = start && busy;
            if (start && !busy)
            begin
                predicted = scheduler_step(cmd);
                rsp_expected_q.push_back(predicted);
                req_cnt[cmd.req_type]++;
                rc_cnt[predicted.result_code]++;
                if (predicted.switched)
                    switch_cnt++;
            end
            if (!present_nxt && sched_cmds_q.size() > 0)
            begin
                if (drain_wait)
                begin
                    if (rsp_expected_q.size() == 0)
                        drain_wait = 1'b0;
                end
                else if (gap_left > 0)
                    gap_left = gap_left - 1;
                else
                begin
                    cmd <= sched_cmds_q.pop_front();
                    present_nxt = 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        // mostly short bursts, sometimes long unbroken runs
                        burst_left = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(20, 60) : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                        drain_wait = ($urandom_range(0, 9) == 0);
                    end
                end
            end
            start <= present_nxt;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: done marks a one-cycle result, taken at the edge
    // that ends that cycle.
    // ------------------------------------------------------------------
    rsp_t oldest_rsp;

    task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rsp_expected_q.size() == 0)
            begin
                $error("result transfer with no request outstanding: %h", rsp);
                err_cnt++;
            end
            else
            begin
                oldest_rsp = rsp_expected_q.pop_front();
                check_field("result_code",   32'(oldest_rsp.result_code),
                            32'(rsp.result_code));
                check_field("new_pid",       32'(oldest_rsp.new_pid),
                            32'(rsp.new_pid));
                check_field("running_pid",   32'(oldest_rsp.running_pid),
                            32'(rsp.running_pid));
                check_field("running_valid", 32'(oldest_rsp.running_valid),
                            32'(rsp.running_valid));
                check_field("switched",      32'(oldest_rsp.switched),
                            32'(rsp.switched));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, rsp_expected_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic cmd_t make_cmd(logic [2:0] op, logic [3:0] tgt, logic [7:0] pr);
        cmd_t c;
        c.req_type   = op;
        c.target_pid = tgt;
        c.privilege  = pr;
        return c;
    endfunction

    // spare codes are queued but not counted as stimulus
    task automatic queue_cmd(cmd_t c);
        sched_cmds_q.push_back(c);
        if (c.req_type != REQ_SPARE_LO && c.req_type != REQ_SPARE_HI)
            stim_cnt++;
    endtask

    function automatic cmd_t rand_cmd();
        int         w;
        logic [2:0] op;
        w = $urandom_range(0, 99);
        if (w < 4)
            op = REQ_CREATE;
        else if (w < 46)
            op = REQ_TICK;
        else if (w < 60)
            op = REQ_BLOCK;
        else if (w < 80)
            op = REQ_UNBLOCK;
        else if (w < 88)
            op = REQ_ENTER;
        else if (w < 96)
            op = REQ_EXIT;
        else
            op = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        return make_cmd(op, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endfunction

    // Wait until every queued request is taken and every result is back.
    // Sampled on the falling edge so the driver's updates have settled.
    task automatic wait_quiet(int settle);
        @(negedge clk);
        while (sched_cmds_q.size() != 0 || start || rsp_expected_q.size() != 0)
            @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apb_write(int idx, logic [5:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= {26'($urandom), val};   // upper bits are don't-care
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(int idx, string rname, logic [5:0] want_v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'(4 * idx);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field(rname, 32'(want_v), 32'(prdata[5:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Slice lengths only change while the scheduler is idle.
    task automatic set_slices(logic [5:0] pv, logic [5:0] us);
        wait_quiet(4);
        apb_write(REG_PRIV_SLICE, pv);
        apb_write(REG_USER_SLICE, us);
        priv_len = pv;
        user_len = us;
        apb_read_check(REG_PRIV_SLICE, "privileged_slice", pv);
        apb_read_check(REG_USER_SLICE, "user_slice", us);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int         pick;
    logic [3:0] pair_tgt;

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_read_check(REG_PRIV_SLICE, "privileged_slice", PRIV_SLICE_RST);
        apb_read_check(REG_USER_SLICE, "user_slice", USER_SLICE_RST);

        // Empty table: tick with no task, bad targets, critical sections,
        // spare codes. Then the first two tasks at reset slice lengths.
        queue_cmd(make_cmd(REQ_TICK,     4'd0,  8'd0));
        queue_cmd(make_cmd(REQ_BLOCK,    4'd15, 8'd0));
        queue_cmd(make_cmd(REQ_UNBLOCK,  4'd0,  8'd255));
        queue_cmd(make_cmd(REQ_ENTER,    4'd0,  8'd0));
        queue_cmd(make_cmd(REQ_EXIT,     4'd0,  8'd0));
        queue_cmd(make_cmd(REQ_SPARE_LO, 4'd5,  8'd7));
        queue_cmd(make_cmd(REQ_SPARE_HI, 4'd10, 8'd200));
        queue_cmd(make_cmd(REQ_CREATE,   4'd0,  8'd0));     // first task runs
        queue_cmd(make_cmd(REQ_CREATE,   4'd15, 8'd255));   // clamped to user
        queue_cmd(make_cmd(REQ_TICK,     4'd0,  8'd0));
        queue_cmd(make_cmd(REQ_BLOCK,    4'd0,  8'd0));     // moves to slot 1
        queue_cmd(make_cmd(REQ_BLOCK,    4'd1,  8'd0));     // nobody ready
        queue_cmd(make_cmd(REQ_TICK,     4'd0,  8'd0));
        queue_cmd(make_cmd(REQ_UNBLOCK,  4'd0,  8'd0));
        queue_cmd(make_cmd(REQ_ENTER,    4'd3,  8'd0));
        queue_cmd(make_cmd(REQ_ENTER,    4'd3,  8'd0));     // nested enter
        queue_cmd(make_cmd(REQ_BLOCK,    4'd15, 8'd0));     // still free slot
        queue_cmd(make_cmd(REQ_EXIT,     4'd0,  8'd0));
        queue_cmd(make_cmd(REQ_EXIT,     4'd0,  8'd0));     // nothing saved left
        queue_cmd(make_cmd(REQ_UNBLOCK,  4'd1,  8'd0));

        // Slice extremes, one way round and then the other
        set_slices(6'd63, 6'd0);
        queue_cmd(make_cmd(REQ_CREATE, 4'd0, 8'd1));
        queue_cmd(make_cmd(REQ_CREATE, 4'd0, 8'd2));
        queue_cmd(make_cmd(REQ_CREATE, 4'd0, 8'd3));
        set_slices(6'd0, 6'd63);
        queue_cmd(make_cmd(REQ_CREATE, 4'd0, 8'd0));
        queue_cmd(make_cmd(REQ_CREATE, 4'd0, 8'd4));
        queue_cmd(make_cmd(REQ_CREATE, 4'd0, 8'd128));

        // Short slices for the rest so expiries come often; then overfill
        set_slices(6'($urandom_range(1, 5)), 6'($urandom_range(0, 3)));
        repeat (SLOTS - 8)
            queue_cmd(make_cmd(REQ_CREATE, 4'($urandom_range(0, 15)),
                               8'($urandom_range(0, 255))));
        queue_cmd(make_cmd(REQ_CREATE, 4'd0, 8'd255));      // table full
        wait_quiet(4);

        // Random traffic: single requests, critical sections wrapped round a
        // few requests, and block/unblock pairs on one slot.
        stim_cnt = 0;
        while (stim_cnt < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                queue_cmd(make_cmd(REQ_ENTER, 4'($urandom), 8'($urandom)));
                repeat ($urandom_range(0, 6))
                    queue_cmd(rand_cmd());
                queue_cmd(make_cmd(REQ_EXIT, 4'($urandom), 8'($urandom)));
            end
            else if (pick < 25)
            begin
                pair_tgt = 4'($urandom_range(0, 15));
                queue_cmd(make_cmd(REQ_BLOCK, pair_tgt, 8'($urandom)));
                repeat ($urandom_range(0, 5))
                    queue_cmd(make_cmd(REQ_TICK, 4'($urandom), 8'($urandom)));
                queue_cmd(make_cmd(REQ_UNBLOCK, pair_tgt, 8'($urandom)));
            end
            else
                queue_cmd(rand_cmd());

            // halfway: let the block drain completely before going on
            if (stim_cnt >= RANDOM_ITEMS / 2 && stim_cnt < RANDOM_ITEMS / 2 + 10)
            begin
                wait_quiet(0);
                stim_cnt = RANDOM_ITEMS / 2 + 10;
            end
        end

        // Drain, then allow for one more worst-case request time
        wait_quiet(SLOTS + 4);

        $display("covered %0d create, %0d tick, %0d block, %0d unblock, %0d enter, %0d exit",
                 req_cnt[REQ_CREATE], req_cnt[REQ_TICK], req_cnt[REQ_BLOCK],
                 req_cnt[REQ_UNBLOCK], req_cnt[REQ_ENTER], req_cnt[REQ_EXIT]);
        $display("%0d task switches, %0d no-ready, %0d table-full, %0d bad-pid, %0d no-task",
                 switch_cnt, rc_cnt[RC_NOREADY], rc_cnt[RC_FULL], rc_cnt[RC_NOPID],
                 rc_cnt[RC_NOTASK]);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
